FILE: sv/mrt_pkg.sv
// mrt_pkg: types, codes and constants for the mesh route table.
// Used by mrt_store, mrt_ctrl and mesh_route_table. No dependencies.
`default_nettype none
package mrt_pkg;
  localparam int ROUTE_ENTRIES = 16;
  localparam int NODE_ID_BYTES = 4;
  localparam int IDX_W = (ROUTE_ENTRIES > 1) ? $clog2(ROUTE_ENTRIES) : 1;
  localparam int ID_BITS = (NODE_ID_BYTES >= 4) ? 32 : 8 * NODE_ID_BYTES;
  localparam logic [31:0] ID_MASK = (ID_BITS >= 32) ? 32'hFFFF_FFFF :
                                    32'((64'd1 << ID_BITS) - 64'd1);

  localparam logic [2:0] KIND_LOOKUP  = 3'd0;
  localparam logic [2:0] KIND_INSTALL = 3'd1;
  localparam logic [2:0] KIND_INVAL   = 3'd2;
  localparam logic [2:0] KIND_TOUCH   = 3'd3;
  localparam logic [2:0] KIND_COLLECT = 3'd4;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] dest_id;
    logic [31:0] next_hop_id;
    logic [7:0]  hops;
    logic [15:0] dest_sequence;
    logic [31:0] now_time;
    logic [31:0] expiry_time;
  } req_t;

  typedef struct packed {
    logic        hit;
    logic [31:0] route_next_hop;
    logic [7:0]  route_hops;
    logic [15:0] route_sequence;
    logic [31:0] route_expiry;
  } rsp_t;

  typedef struct packed {
    logic [31:0] dest;
    logic [31:0] gateway;
    logic [7:0]  hops;
    logic [15:0] sequence_num;
    logic [31:0] expiry;
    logic [31:0] last_used;
  } entry_t;

  typedef struct packed {
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    entry_t            wr_data;
  } mem_req_t;

  function automatic logic time_before(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] d;
    d = a - b;
    return d[31];
  endfunction

  function automatic logic is_expired(input logic [31:0] expiry, input logic [31:0] now);
    logic [31:0] d;
    d = expiry - now;
    return (d == 32'd0) || d[31];
  endfunction

  function automatic logic seq_newer(input logic [15:0] a, input logic [15:0] b);
    logic [15:0] d;
    d = a - b;
    return (d != 16'd0) && !d[15];
  endfunction
endpackage
`default_nettype wire

FILE: sv/mrt_store.sv
// mrt_store: entry memory, one write and one registered read per cycle.
// Depends on mrt_pkg.
`default_nettype none
module mrt_store (
  input  logic              clk,
  input  mrt_pkg::mem_req_t req,
  output mrt_pkg::entry_t   rd_data
);
  import mrt_pkg::*;

  entry_t mem [ROUTE_ENTRIES];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end
endmodule
`default_nettype wire

FILE: sv/mrt_ctrl.sv
// mrt_ctrl: sequencer that scans the entry memory once per operation,
// then may write back the chosen slot (install, touch, lookup hit). Depends on mrt_pkg.
`default_nettype none
module mrt_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  mrt_pkg::req_t     req_in,
  output logic              busy,
  output logic              done,
  output mrt_pkg::rsp_t     result,
  output mrt_pkg::mem_req_t mem,
  input  mrt_pkg::entry_t   rd_data
);
  import mrt_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_WB   = 2'd2;

  localparam int CNT_W = IDX_W + 1;

  logic [1:0]             state;
  req_t                   op;
  logic [ROUTE_ENTRIES-1:0] valid;
  logic [CNT_W-1:0]       rd_cnt;
  logic                   data_vld;
  logic [IDX_W-1:0]       data_idx;
  logic                   found;
  logic [IDX_W-1:0]       found_idx;
  entry_t                 found_ent;
  logic                   free_found;
  logic [IDX_W-1:0]       free_idx;
  logic [IDX_W-1:0]       lru_idx;
  logic [31:0]            lru_time;
  logic                   lru_set;
  logic [31:0]            dest_m;
  logic [31:0]            nhop_m;
  logic                   match;

  assign dest_m = op.dest_id & ID_MASK;
  assign nhop_m = op.next_hop_id & ID_MASK;
  assign busy   = (state != ST_IDLE);
  assign match  = data_vld && valid[data_idx] && (rd_data.dest == dest_m);

  always_comb begin
    mem = '0;
    if (state == ST_SCAN && rd_cnt < CNT_W'(ROUTE_ENTRIES)) begin
      mem.rd_en   = 1'b1;
      mem.rd_addr = rd_cnt[IDX_W-1:0];
    end
    if (state == ST_WB && op.kind == KIND_INSTALL) begin
      mem.wr_addr               = found ? found_idx : (free_found ? free_idx : lru_idx);
      mem.wr_data.dest          = dest_m;
      mem.wr_data.gateway       = nhop_m;
      mem.wr_data.hops          = op.hops;
      mem.wr_data.sequence_num  = op.dest_sequence;
      mem.wr_data.expiry        = op.expiry_time;
      mem.wr_data.last_used     = op.now_time;
      mem.wr_en = !found || seq_newer(op.dest_sequence, found_ent.sequence_num) ||
                  (op.dest_sequence == found_ent.sequence_num &&
                   op.hops < found_ent.hops);
    end else if (state == ST_WB && found &&
                 (op.kind == KIND_TOUCH ||
                  (op.kind == KIND_LOOKUP && !is_expired(found_ent.expiry, op.now_time)))) begin
      mem.wr_en             = 1'b1;
      mem.wr_addr           = found_idx;
      mem.wr_data           = found_ent;
      mem.wr_data.last_used = op.now_time;
      if (op.kind == KIND_TOUCH) begin
        mem.wr_data.expiry = op.expiry_time;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      valid    <= '0;
      done     <= 1'b0;
      data_vld <= 1'b0;
    end else begin
      done     <= 1'b0;
      data_vld <= mem.rd_en;
      data_idx <= mem.rd_addr;
      case (state)
        ST_IDLE: begin
          if (start) begin
            op         <= req_in;
            rd_cnt     <= '0;
            found      <= 1'b0;
            free_found <= 1'b0;
            lru_set    <= 1'b0;
            state      <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (rd_cnt < CNT_W'(ROUTE_ENTRIES)) begin
            rd_cnt <= rd_cnt + 1'b1;
          end
          if (data_vld) begin
            if (match && !found) begin
              found     <= 1'b1;
              found_idx <= data_idx;
              found_ent <= rd_data;
            end
            if (!valid[data_idx] && !free_found) begin
              free_found <= 1'b1;
              free_idx   <= data_idx;
            end
            if (!lru_set || time_before(rd_data.last_used, lru_time)) begin
              lru_set  <= 1'b1;
              lru_idx  <= data_idx;
              lru_time <= rd_data.last_used;
            end
            if (op.kind == KIND_COLLECT && valid[data_idx] &&
                is_expired(rd_data.expiry, op.now_time)) begin
              valid[data_idx] <= 1'b0;
            end
            if (data_idx == IDX_W'(ROUTE_ENTRIES - 1)) begin
              state <= ST_WB;
            end
          end
        end
        ST_WB: begin
          done   <= 1'b1;
          result <= '0;
          state  <= ST_IDLE;
          case (op.kind)
            KIND_LOOKUP: begin
              if (found && !is_expired(found_ent.expiry, op.now_time)) begin
                result <= {1'b1, found_ent.gateway, found_ent.hops,
                           found_ent.sequence_num, found_ent.expiry};
              end
            end
            KIND_INSTALL: begin
              if (mem.wr_en) begin
                valid[mem.wr_addr] <= 1'b1;
                result <= {1'b1, nhop_m, op.hops, op.dest_sequence, op.expiry_time};
              end
            end
            KIND_INVAL: begin
              if (found) begin
                valid[found_idx] <= 1'b0;
                result <= {1'b1, found_ent.gateway, found_ent.hops,
                           found_ent.sequence_num, found_ent.expiry};
              end
            end
            KIND_TOUCH: begin
              if (found) begin
                result <= {1'b1, found_ent.gateway, found_ent.hops,
                           found_ent.sequence_num, op.expiry_time};
              end
            end
            default: begin
            end
          endcase
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_done_once: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("done held two cycles");
  a_no_wr_scan: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> !mem.wr_en) else $error("write during scan");
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("start not taken");
endmodule
`default_nettype wire

FILE: sv/mesh_route_table.sv
// mesh_route_table: route table top level, sequencer plus entry memory.
// Each operation reads all 16 entries in turn through the single read port,
// then may write back the chosen slot and registers the result with the done
// strobe; a new start is taken only once busy has dropped. The receiver
// cannot stall. Synchronous reset clears the valid flags; entry contents
// stay undefined until installed.
// Depends on mrt_pkg, mrt_ctrl, mrt_store.
`default_nettype none
module mesh_route_table (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  mrt_pkg::req_t  req,
  output logic           busy,
  output logic           done,
  output mrt_pkg::rsp_t  rsp
);
  import mrt_pkg::*;

  mem_req_t mem;
  entry_t   rd_data;

  mrt_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .req_in  (req),
    .busy    (busy),
    .done    (done),
    .result  (rsp),
    .mem     (mem),
    .rd_data (rd_data)
  );

  mrt_store u_store (
    .clk     (clk),
    .req     (mem),
    .rd_data (rd_data)
  );
endmodule
`default_nettype wire

FILE: test/mesh_route_table_checker.sv
// mesh_route_table_checker: watches request and response beats of the route
// table, keeps its own copy of the table and compares responses in order.
// Depends on mrt_pkg.
module mesh_route_table_checker (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic           busy,
  input  mrt_pkg::req_t  req,
  input  logic           done,
  input  mrt_pkg::rsp_t  rsp,
  output int             fail_count,
  output int             pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import mrt_pkg::*;

  logic        tbl_valid [ROUTE_ENTRIES];
  logic [31:0] tbl_dest  [ROUTE_ENTRIES];
  logic [31:0] tbl_nhop  [ROUTE_ENTRIES];
  logic [7:0]  tbl_hops  [ROUTE_ENTRIES];
  logic [15:0] tbl_seq   [ROUTE_ENTRIES];
  logic [31:0] tbl_exp   [ROUTE_ENTRIES];
  logic [31:0] tbl_used  [ROUTE_ENTRIES];
  rsp_t        route_answers[$];

  function automatic logic past(input logic [31:0] e, input logic [31:0] n);
    logic [31:0] d;
    d = e - n;
    return (d == 0) || d[31];
  endfunction

  function automatic int slot_of(input logic [31:0] d);
    for (int i = 0; i < ROUTE_ENTRIES; i++)
      if (tbl_valid[i] && tbl_dest[i] == d) return i;
    return -1;
  endfunction

  function automatic rsp_t answer_of(input int s);
    rsp_t r;
    r.hit = 1'b1;
    r.route_next_hop = tbl_nhop[s];
    r.route_hops = tbl_hops[s];
    r.route_sequence = tbl_seq[s];
    r.route_expiry = tbl_exp[s];
    return r;
  endfunction

  function automatic rsp_t apply_op(input req_t q);
    rsp_t r;
    int s;
    logic [31:0] d, nh;
    logic [15:0] sd;
    logic better;
    r = '0;
    d = q.dest_id & ID_MASK;
    nh = q.next_hop_id & ID_MASK;
    s = slot_of(d);
    case (q.kind)
      KIND_LOOKUP: begin
        if (s >= 0 && !past(tbl_exp[s], q.now_time)) begin
          tbl_used[s] = q.now_time;
          r = answer_of(s);
        end
      end
      KIND_INSTALL: begin
        better = 1'b1;
        if (s >= 0) begin
          sd = q.dest_sequence - tbl_seq[s];
          better = (sd != 0 && !sd[15]) ||
                   (q.dest_sequence == tbl_seq[s] && q.hops < tbl_hops[s]);
        end else begin
          for (int i = 0; i < ROUTE_ENTRIES; i++)
            if (s < 0 && !tbl_valid[i]) s = i;
          if (s < 0) begin
            s = 0;
            for (int i = 1; i < ROUTE_ENTRIES; i++)
              if (((tbl_used[i] - tbl_used[s]) >> 31) != 0) s = i;
          end
        end
        if (better) begin
          tbl_dest[s] = d;
          tbl_nhop[s] = nh;
          tbl_hops[s] = q.hops;
          tbl_seq[s] = q.dest_sequence;
          tbl_exp[s] = q.expiry_time;
          tbl_used[s] = q.now_time;
          tbl_valid[s] = 1'b1;
          r = answer_of(s);
        end
      end
      KIND_INVAL: begin
        if (s >= 0) begin
          r = answer_of(s);
          tbl_valid[s] = 1'b0;
        end
      end
      KIND_TOUCH: begin
        if (s >= 0) begin
          tbl_exp[s] = q.expiry_time;
          tbl_used[s] = q.now_time;
          r = answer_of(s);
        end
      end
      KIND_COLLECT: begin
        for (int i = 0; i < ROUTE_ENTRIES; i++)
          if (tbl_valid[i] && past(tbl_exp[i], q.now_time)) tbl_valid[i] = 1'b0;
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      for (int i = 0; i < ROUTE_ENTRIES; i++) tbl_valid[i] = 1'b0;
      route_answers.delete();
      fail_count = 0;
    end else begin
      if (done) begin
        if (route_answers.size() == 0) begin
          $error("response beat with nothing expected");
          fail_count++;
        end else begin
          want = route_answers.pop_front();
          if (rsp.hit !== want.hit) begin
            $error("hit: expected %0h, got %0h", want.hit, rsp.hit);
            fail_count++;
          end
          if (rsp.route_next_hop !== want.route_next_hop) begin
            $error("route_next_hop: expected %0h, got %0h",
                   want.route_next_hop, rsp.route_next_hop);
            fail_count++;
          end
          if (rsp.route_hops !== want.route_hops) begin
            $error("route_hops: expected %0h, got %0h", want.route_hops, rsp.route_hops);
            fail_count++;
          end
          if (rsp.route_sequence !== want.route_sequence) begin
            $error("route_sequence: expected %0h, got %0h",
                   want.route_sequence, rsp.route_sequence);
            fail_count++;
          end
          if (rsp.route_expiry !== want.route_expiry) begin
            $error("route_expiry: expected %0h, got %0h",
                   want.route_expiry, rsp.route_expiry);
            fail_count++;
          end
        end
      end
      if (start && !busy) route_answers.push_back(apply_op(req));
    end
    pending = route_answers.size();
  end
endmodule

FILE: test/mesh_route_table_tb.sv
// mesh_route_table_tb: drives lookup/install/invalidate/touch/collect beats,
// and beats with undefined kind codes, into the route table;
// mesh_route_table_checker predicts and compares. Depends on mrt_pkg, mesh_route_table, mesh_route_table_checker.
module mesh_route_table_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mrt_pkg::*;

  localparam int LIMIT = 400000;

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  logic  start = 1'b0;
  req_t  req = '0;
  logic  busy, done;
  rsp_t  rsp;
  int    fail_count, pending;
  int    cycles = 0;
  logic [31:0] clock_ms = 32'd1000;
  logic [31:0] dest_pool[8];
  logic        calm = 1'b0;

  mesh_route_table u_dut (
    .clk(clk), .rst(rst), .start(start), .req(req),
    .busy(busy), .done(done), .rsp(rsp)
  );

  mesh_route_table_checker u_chk (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req(req),
    .done(done), .rsp(rsp), .fail_count(fail_count), .pending(pending)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("** mesh_route_table: FAILED **");
      $finish;
    end
  end

  task automatic send_beat(input logic [2:0] k, input logic [31:0] d, input logic [31:0] nh,
                           input logic [7:0] h, input logic [15:0] sq,
                           input logic [31:0] now, input logic [31:0] ex);
    @(negedge clk);
    while (!calm && $urandom_range(99) < 14) @(negedge clk);
    start <= 1'b1;
    req <= '{kind: k, dest_id: d, next_hop_id: nh, hops: h, dest_sequence: sq,
             now_time: now, expiry_time: ex};
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
    start <= 1'b0;
    req <= '0;
  endtask

  task automatic random_beat();
    logic [2:0]  k;
    logic [31:0] d, ex;
    int roll;
    roll = $urandom_range(99);
    if (roll < 30) k = KIND_INSTALL;
    else if (roll < 60) k = KIND_LOOKUP;
    else if (roll < 72) k = KIND_INVAL;
    else if (roll < 84) k = KIND_TOUCH;
    else if (roll < 93) k = KIND_COLLECT;
    else k = 3'($urandom_range(7));
    d = ($urandom_range(9) == 0) ? $urandom : dest_pool[3'($urandom_range(7))];
    clock_ms = clock_ms + $urandom_range(40);
    if ($urandom_range(19) == 0) clock_ms = $urandom;
    ex = ($urandom_range(9) == 0) ? $urandom : clock_ms + $urandom_range(400) - 50;
    send_beat(k, d, $urandom, 8'(($urandom_range(3) == 0) ? $urandom : $urandom_range(6)),
              16'(($urandom_range(3) == 0) ? $urandom : $urandom_range(4)),
              clock_ms, ex);
  endtask

  initial begin
    for (int i = 0; i < 8; i++) dest_pool[i] = $urandom;
    dest_pool[0] = 32'h0;
    dest_pool[1] = 32'hFFFF_FFFF;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: extremes, every kind, serial wrap, replacement rules
    send_beat(KIND_LOOKUP, 32'h0, 0, 0, 0, 0, 0);
    send_beat(KIND_INSTALL, 32'h0, 32'hFFFF_FFFF, 8'hFF, 16'hFFFF, 32'hFFFF_FFF0, 32'h10);
    send_beat(KIND_LOOKUP, 32'h0, 0, 0, 0, 32'hFFFF_FFFF, 0);
    send_beat(KIND_INSTALL, 32'h0, 32'h1, 8'h3, 16'h0000, 32'h5, 32'h20);
    send_beat(KIND_INSTALL, 32'h0, 32'h2, 8'h4, 16'h0000, 32'h6, 32'h30);
    send_beat(KIND_INSTALL, 32'h0, 32'h3, 8'h2, 16'h0000, 32'h7, 32'h30);
    send_beat(KIND_INSTALL, 32'h0, 32'h4, 8'h0, 16'h8000, 32'h7, 32'h30);
    send_beat(KIND_LOOKUP, 32'h0, 0, 0, 0, 32'h30, 0);
    send_beat(KIND_TOUCH, 32'h0, 0, 0, 0, 32'h31, 32'h8000_0000);
    send_beat(KIND_LOOKUP, 32'h0, 0, 0, 0, 32'h40, 0);
    send_beat(KIND_INSTALL, 32'hFFFF_FFFF, 32'h0, 8'h0, 16'h7FFF, 32'h41, 32'h50);
    send_beat(KIND_COLLECT, 0, 0, 0, 0, 32'h50, 0);
    send_beat(KIND_LOOKUP, 32'hFFFF_FFFF, 0, 0, 0, 32'h42, 0);
    send_beat(KIND_INVAL, 32'h0, 0, 0, 0, 0, 0);
    send_beat(KIND_INVAL, 32'h0, 0, 0, 0, 0, 0);
    send_beat(KIND_TOUCH, 32'h1234, 0, 0, 0, 0, 0);
    send_beat(3'd5, 32'h1, 0, 0, 0, 0, 0);
    send_beat(3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // fill beyond capacity to force least-recently-used eviction
    for (int i = 0; i < 18; i++)
      send_beat(KIND_INSTALL, 32'h100 + i, i, 1, 1, 32'h100 + (i % 5), 32'h9000);

    for (int n = 0; n < 1550; n++) begin
      calm = (n >= 600 && n < 800);
      if (n == 900) wait (pending == 0);
      random_beat();
    end

    wait (pending == 0);
    repeat (40) @(posedge clk);
    if (fail_count == 0)
      $display("** mesh_route_table: PASSED **");
    else
      $display("** mesh_route_table: FAILED **");
    $finish;
  end
endmodule
